/* rtl/core/rbc_pkg.sv */
// ----------------------------------------------------------------------------
// rbc_pkg
// Types and codes shared by the reorder buffer commit core and its parts.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam logic [2:0] MODE_DISPATCH  = 3'd0;
  localparam logic [2:0] MODE_WRITEBACK = 3'd1;
  localparam logic [2:0] MODE_MARK      = 3'd2;
  localparam logic [2:0] MODE_STORE_WB  = 3'd3;
  localparam logic [2:0] MODE_COMMIT    = 3'd4;

  localparam logic [3:0] KIND_BRANCH  = 4'd0;
  localparam logic [3:0] KIND_STORE_B = 4'd1;
  localparam logic [3:0] KIND_STORE_H = 4'd2;
  localparam logic [3:0] KIND_STORE_W = 4'd3;
  localparam logic [3:0] KIND_REG     = 4'd4;
  localparam logic [3:0] KIND_JALR    = 4'd5;
  localparam logic [3:0] KIND_BR_OK   = 4'd7;
  localparam logic [3:0] KIND_BR_BAD  = 4'd8;

  localparam logic [3:0] RES_NONE   = 4'd0;
  localparam logic [3:0] RES_ALLOC  = 4'd1;
  localparam logic [3:0] RES_BCAST  = 4'd2;
  localparam logic [3:0] RES_REG    = 4'd3;
  localparam logic [3:0] RES_STORE  = 4'd4;
  localparam logic [3:0] RES_BROK   = 4'd5;
  localparam logic [3:0] RES_MISP   = 4'd6;
  localparam logic [3:0] RES_JALR   = 4'd7;
  localparam logic [3:0] RES_EXIT   = 4'd8;
  localparam logic [3:0] RES_FULL   = 4'd9;
  localparam logic [3:0] RES_UNRES  = 4'd10;

  localparam logic [2:0] BYTES_1 = 3'd1;
  localparam logic [2:0] BYTES_2 = 3'd2;
  localparam logic [2:0] BYTES_4 = 3'd4;

  localparam logic [31:0] INSN_BYTES = 32'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  entry_kind;
    logic [3:0]  slot_index;
    logic [31:0] data_in;
    logic [31:0] dest_in;
    logic [31:0] pc_in;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [3:0]  slot_out;
    logic [31:0] data_out;
    logic [31:0] target_out;
    logic [2:0]  store_bytes;
    logic [31:0] branch_pc;
    logic        branch_taken;
    logic        redirect_valid;
    logic [31:0] redirect_pc;
    logic        slot_free;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [31:0] dest;
    logic [31:0] pc;
  } slot_entry_t;

  typedef struct packed {
    logic busy;
    logic ready;
    logic in_range;
  } slot_status_t;

  typedef struct packed {
    logic mem_we;
    logic set_ready;
    logic alloc;
    logic retire;
  } step_ctrl_t;

endpackage

/* rtl/core/rbc_slot_ram.sv */
// ----------------------------------------------------------------------------
// rbc_slot_ram
// Slot payload memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rbc_slot_ram
  import rbc_pkg::*;
#(
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_entry_t       wr_data
);

  slot_entry_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/rbc_step.sv */
// ----------------------------------------------------------------------------
// rbc_step
// Decides one item from the slot read back: the new slot contents, the flag
// updates and the result item.
// ----------------------------------------------------------------------------
module rbc_step
  import rbc_pkg::*;
(
  input  cmd_t         cmd,
  input  slot_entry_t  entry,
  input  slot_status_t status,
  input  logic [3:0]   tag,
  output slot_entry_t  wr_entry,
  output step_ctrl_t   ctrl,
  output rsp_t         rsp
);

  logic taken;

  assign taken = (entry.value != 32'd0);

  always_comb begin
    wr_entry = entry;
    ctrl     = '0;
    rsp      = '0;
    case (cmd.mode)
      MODE_DISPATCH: begin
        if (status.busy) begin
          rsp.result_kind = RES_FULL;
        end else begin
          wr_entry.kind   = {1'b0, cmd.entry_kind};
          wr_entry.value  = cmd.data_in;
          wr_entry.dest   = cmd.dest_in;
          wr_entry.pc     = cmd.pc_in;
          ctrl.mem_we     = 1'b1;
          ctrl.alloc      = 1'b1;
          rsp.result_kind = RES_ALLOC;
          rsp.slot_out    = tag;
        end
      end
      MODE_WRITEBACK: begin
        if (status.in_range) begin
          if (entry.kind == KIND_BRANCH) begin
            wr_entry.kind = (cmd.data_in == entry.value) ? KIND_BR_OK : KIND_BR_BAD;
          end
          wr_entry.value  = cmd.data_in;
          ctrl.mem_we     = 1'b1;
          ctrl.set_ready  = 1'b1;
          rsp.result_kind = RES_BCAST;
          rsp.slot_out    = tag;
          rsp.data_out    = cmd.data_in;
        end
      end
      MODE_MARK: begin
        if (status.in_range) begin
          ctrl.set_ready  = 1'b1;
          rsp.result_kind = RES_BCAST;
          rsp.slot_out    = tag;
          rsp.data_out    = entry.value;
        end
      end
      MODE_STORE_WB: begin
        if (status.in_range) begin
          wr_entry.value = cmd.data_in;
          wr_entry.dest  = cmd.dest_in;
          ctrl.mem_we    = 1'b1;
          ctrl.set_ready = 1'b1;
        end
      end
      MODE_COMMIT: begin
        if (status.busy && status.ready) begin
          rsp.slot_out = tag;
          if (entry.kind == KIND_BRANCH) begin
            rsp.result_kind = RES_UNRES;
          end else begin
            ctrl.retire = 1'b1;
            case (entry.kind)
              KIND_STORE_B, KIND_STORE_H, KIND_STORE_W: begin
                rsp.result_kind = RES_STORE;
                rsp.data_out    = entry.value;
                rsp.target_out  = entry.dest;
                rsp.store_bytes = (entry.kind == KIND_STORE_B) ? BYTES_1 :
                                  (entry.kind == KIND_STORE_H) ? BYTES_2 : BYTES_4;
              end
              KIND_REG: begin
                rsp.result_kind = RES_REG;
                rsp.data_out    = entry.value;
                rsp.target_out  = entry.dest;
              end
              KIND_JALR: begin
                rsp.result_kind    = RES_JALR;
                rsp.data_out       = entry.pc + INSN_BYTES;
                rsp.target_out     = entry.dest;
                rsp.redirect_valid = 1'b1;
                rsp.redirect_pc    = entry.value;
              end
              KIND_BR_OK: begin
                rsp.result_kind  = RES_BROK;
                rsp.branch_pc    = entry.pc;
                rsp.branch_taken = taken;
              end
              KIND_BR_BAD: begin
                rsp.result_kind    = RES_MISP;
                rsp.branch_pc      = entry.pc;
                rsp.branch_taken   = taken;
                rsp.redirect_valid = 1'b1;
                rsp.redirect_pc    = taken ? entry.dest : entry.pc + INSN_BYTES;
              end
              default: begin
                rsp.result_kind = RES_EXIT;
              end
            endcase
          end
        end
      end
      default: begin
        rsp.result_kind = RES_NONE;
      end
    endcase
  end

endmodule

/* rtl/core/reorder_buffer_commit_core.sv */
// ----------------------------------------------------------------------------
// reorder_buffer_commit_core
// Circular reorder buffer with dispatch, writeback and in-order commit.
// The item and its slot are read into registers when it is accepted, and the
// result item is registered once the output is free. A new item is taken only
// after the last one's result is registered. A waiting result holds up the next
// item after its read. Reset clears the pointers and the busy and ready flags;
// slot memory is not cleared.
// ----------------------------------------------------------------------------
module reorder_buffer_commit_core
  import rbc_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (PTR_W > 4) ? PTR_W : 4;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [DEPTH-1:0] busy;
  logic [DEPTH-1:0] ready;
  cmd_t             item;
  logic [PTR_W-1:0] addr;
  logic             in_range;

  logic             accept;
  logic             go;
  logic [XW-1:0]    idx_x;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_in_range;
  slot_entry_t      rd_data;
  slot_entry_t      wr_entry;
  slot_status_t     status;
  step_ctrl_t       ctrl;
  rsp_t             step_rsp;
  rsp_t             rsp_next;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic             free_after;

  assign cmd_ready = (state == ST_IDLE) && !rst;
  assign accept    = cmd_valid && cmd_ready;
  assign go        = (state == ST_EXEC) && (!rsp_valid || rsp_ready);

  assign idx_x       = XW'(cmd.slot_index);
  assign rd_in_range = ({1'b0, idx_x} < (XW + 1)'(DEPTH));

  always_comb begin
    case (cmd.mode)
      MODE_DISPATCH: rd_addr = tail;
      MODE_COMMIT:   rd_addr = head;
      default:       rd_addr = idx_x[PTR_W-1:0];
    endcase
  end

  rbc_slot_ram #(
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (go && ctrl.mem_we),
    .wr_addr(addr),
    .wr_data(wr_entry)
  );

  assign status.busy     = busy[addr];
  assign status.ready    = ready[addr];
  assign status.in_range = in_range;

  rbc_step u_step (
    .cmd     (item),
    .entry   (rd_data),
    .status  (status),
    .tag     (4'(addr)),
    .wr_entry(wr_entry),
    .ctrl    (ctrl),
    .rsp     (step_rsp)
  );

  assign head_next  = (head == LAST) ? '0 : head + 1'b1;
  assign tail_next  = ctrl.alloc ? ((tail == LAST) ? '0 : tail + 1'b1) : tail;
  assign free_after = !busy[tail_next] || (ctrl.retire && (addr == tail_next));

  always_comb begin
    rsp_next           = step_rsp;
    rsp_next.slot_free = free_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      busy      <= '0;
      ready     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && !go) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        state <= ST_EXEC;
      end
      if (go) begin
        state     <= ST_IDLE;
        rsp_valid <= 1'b1;
        tail      <= tail_next;
        if (ctrl.alloc) begin
          busy[addr]  <= 1'b1;
          ready[addr] <= 1'b0;
        end
        if (ctrl.set_ready) begin
          ready[addr] <= 1'b1;
        end
        if (ctrl.retire) begin
          busy[addr]  <= 1'b0;
          ready[addr] <= 1'b0;
          head        <= head_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item     <= cmd;
      addr     <= rd_addr;
      in_range <= rd_in_range;
    end
    if (go) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* tb/tb_reorder_buffer_commit_core.sv */
// ----------------------------------------------------------------------------
// tb_reorder_buffer_commit_core
// Drives dispatch, writeback, mark-ready, store writeback and commit items
// into the reorder buffer with random idle cycles and output stalls. A copy of
// the buffer state kept in the bench predicts every result item, and each
// result is checked field by field, in order, against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reorder_buffer_commit_core;
  import rbc_pkg::*;

  localparam int SLOTS = 16;
  localparam int CLK_PERIOD = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS = 23;
  localparam int SEGMENT_ITEMS = 50;

  localparam logic [3:0] KIND_EXIT  = 4'd6;
  localparam logic [3:0] KIND_SPARE = 4'd7;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic [3:0]  rob_kind [SLOTS];
  logic [31:0] rob_value [SLOTS];
  logic [31:0] rob_dest [SLOTS];
  logic [31:0] rob_pc [SLOTS];
  logic        rob_ready [SLOTS];
  logic        rob_busy [SLOTS];
  logic        rob_dispatched [SLOTS];
  logic [3:0]  rob_head;
  logic [3:0]  rob_tail;

  rsp_t results_due[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   stall_left = 0;
  bit   source_gaps = 1'b1;
  bit   sink_stalls = 1'b1;

  reorder_buffer_commit_core #(
    .DEPTH(SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [3:0] next_slot(logic [3:0] p);
    return (p == SLOTS - 1) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic rsp_t rob_apply(cmd_t c);
    rsp_t r;
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] k;
    logic [3:0] i;
    r = '0;
    i = c.slot_index;
    case (c.mode)
      MODE_DISPATCH: begin
        t = rob_tail;
        if (rob_busy[t]) begin
          r.result_kind = RES_FULL;
        end else begin
          rob_kind[t] = {1'b0, c.entry_kind};
          rob_value[t] = c.data_in;
          rob_dest[t] = c.dest_in;
          rob_pc[t] = c.pc_in;
          rob_ready[t] = 1'b0;
          rob_busy[t] = 1'b1;
          rob_dispatched[t] = 1'b1;
          r.result_kind = RES_ALLOC;
          r.slot_out = t;
          rob_tail = next_slot(t);
        end
      end
      MODE_WRITEBACK: begin
        if (rob_kind[i] == KIND_BRANCH) begin
          rob_kind[i] = (c.data_in == rob_value[i]) ? KIND_BR_OK : KIND_BR_BAD;
        end
        rob_value[i] = c.data_in;
        rob_ready[i] = 1'b1;
        r.result_kind = RES_BCAST;
        r.slot_out = i;
        r.data_out = c.data_in;
      end
      MODE_MARK: begin
        rob_ready[i] = 1'b1;
        r.result_kind = RES_BCAST;
        r.slot_out = i;
        r.data_out = rob_value[i];
      end
      MODE_STORE_WB: begin
        rob_value[i] = c.data_in;
        rob_dest[i] = c.dest_in;
        rob_ready[i] = 1'b1;
      end
      MODE_COMMIT: begin
        h = rob_head;
        if (rob_busy[h] && rob_ready[h]) begin
          k = rob_kind[h];
          r.slot_out = h;
          if (k == KIND_BRANCH) begin
            r.result_kind = RES_UNRES;
          end else begin
            case (k)
              KIND_STORE_B, KIND_STORE_H, KIND_STORE_W: begin
                r.result_kind = RES_STORE;
                r.data_out = rob_value[h];
                r.target_out = rob_dest[h];
                r.store_bytes = (k == KIND_STORE_B) ? BYTES_1 :
                                (k == KIND_STORE_H) ? BYTES_2 : BYTES_4;
              end
              KIND_REG: begin
                r.result_kind = RES_REG;
                r.data_out = rob_value[h];
                r.target_out = rob_dest[h];
              end
              KIND_JALR: begin
                r.result_kind = RES_JALR;
                r.data_out = rob_pc[h] + INSN_BYTES;
                r.target_out = rob_dest[h];
                r.redirect_valid = 1'b1;
                r.redirect_pc = rob_value[h];
              end
              KIND_BR_OK: begin
                r.result_kind = RES_BROK;
                r.branch_pc = rob_pc[h];
                r.branch_taken = (rob_value[h] != 0);
              end
              KIND_BR_BAD: begin
                r.result_kind = RES_MISP;
                r.branch_pc = rob_pc[h];
                r.branch_taken = (rob_value[h] != 0);
                r.redirect_valid = 1'b1;
                r.redirect_pc = (rob_value[h] == 0) ? rob_pc[h] + INSN_BYTES : rob_dest[h];
              end
              default: begin
                r.result_kind = RES_EXIT;
              end
            endcase
            rob_busy[h] = 1'b0;
            rob_ready[h] = 1'b0;
            rob_head = next_slot(h);
          end
        end
      end
      default: begin
      end
    endcase
    r.slot_free = !rob_busy[rob_tail];
    return r;
  endfunction

  function automatic int pause_len(bit enabled);
    if (!enabled || $urandom_range(99) >= 30) begin
      return 0;
    end
    return ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(63);
      default: return $urandom;
    endcase
  endfunction

  // Slots still waiting for a value (or holding an unresolved branch) are
  // preferred, so that most writebacks move real work forward.
  function automatic int choose_slot();
    int open_q[$];
    int busy_q[$];
    int seen_q[$];
    for (int s = 0; s < SLOTS; s++) begin
      if (rob_dispatched[s]) seen_q.push_back(s);
      if (rob_busy[s]) busy_q.push_back(s);
      if (rob_busy[s] && (!rob_ready[s] || rob_kind[s] == KIND_BRANCH)) open_q.push_back(s);
    end
    if (open_q.size() != 0 && $urandom_range(9) != 0) begin
      return open_q[$urandom_range(open_q.size() - 1)];
    end
    if (busy_q.size() != 0 && $urandom_range(3) != 0) begin
      return busy_q[$urandom_range(busy_q.size() - 1)];
    end
    if (seen_q.size() != 0) begin
      return seen_q[$urandom_range(seen_q.size() - 1)];
    end
    return -1;
  endfunction

  function automatic cmd_t random_cmd(int dispatch_pct);
    cmd_t c;
    int roll;
    int slot;
    c.mode = MODE_COMMIT;
    c.entry_kind = 3'($urandom_range(7));
    c.slot_index = 4'($urandom_range(SLOTS - 1));
    c.data_in = random_word();
    c.dest_in = random_word();
    c.pc_in = random_word();
    roll = $urandom_range(99);
    if (roll < 3) begin
      c.mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
      return c;
    end
    if (roll < 3 + dispatch_pct) begin
      c.mode = MODE_DISPATCH;
      if ({1'b0, c.entry_kind} == KIND_BRANCH && $urandom_range(1) == 1) begin
        c.data_in = $urandom_range(1);
      end
      return c;
    end
    roll = $urandom_range(99);
    slot = choose_slot();
    if (roll < 40 && slot >= 0) begin
      c.mode = MODE_WRITEBACK;
      c.slot_index = 4'(slot);
      if (rob_kind[slot] == KIND_BRANCH && $urandom_range(1) == 1) begin
        c.data_in = rob_value[slot];
      end
    end else if (roll < 50 && slot >= 0) begin
      c.mode = MODE_MARK;
      c.slot_index = 4'(slot);
    end else if (roll < 65) begin
      c.mode = MODE_STORE_WB;
      if (slot >= 0 && $urandom_range(4) != 0) c.slot_index = 4'(slot);
    end
    return c;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] mode, logic [3:0] kind, logic [3:0] slot,
                                    logic [31:0] data, logic [31:0] dest, logic [31:0] pc);
    cmd_t c;
    c.mode = mode;
    c.entry_kind = kind[2:0];
    c.slot_index = slot;
    c.data_in = data;
    c.dest_in = dest;
    c.pc_in = pc;
    return c;
  endfunction

  task automatic send_item(input cmd_t c);
    int gap;
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    results_due.push_back(rob_apply(c));
    gap = pause_len(source_gaps);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch in %0s at cycle %0d: expected %h, got %h",
                 name, cycle_count, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result at cycle %0d: kind %0d slot %0d",
                   cycle_count, rsp.result_kind, rsp.slot_out);
        end
      end else begin
        want = results_due.pop_front();
        compare_field("result_kind", 32'(want.result_kind), 32'(rsp.result_kind));
        compare_field("slot_out", 32'(want.slot_out), 32'(rsp.slot_out));
        compare_field("data_out", want.data_out, rsp.data_out);
        compare_field("target_out", want.target_out, rsp.target_out);
        compare_field("store_bytes", 32'(want.store_bytes), 32'(rsp.store_bytes));
        compare_field("branch_pc", want.branch_pc, rsp.branch_pc);
        compare_field("branch_taken", 32'(want.branch_taken), 32'(rsp.branch_taken));
        compare_field("redirect_valid", 32'(want.redirect_valid), 32'(rsp.redirect_valid));
        compare_field("redirect_pc", want.redirect_pc, rsp.redirect_pc);
        compare_field("slot_free", 32'(want.slot_free), 32'(rsp.slot_free));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(99) < 20) begin
      rsp_ready <= 1'b0;
      stall_left <= pause_len(1'b1);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_idle_cases();
    send_item(make_cmd(MODE_COMMIT, KIND_BRANCH, 4'd0, 32'd0, 32'd0, 32'd0));
    send_item(make_cmd(MODE_STORE_WB, KIND_BRANCH, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF));
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      send_item(make_cmd(3'(m), KIND_SPARE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF));
    end
  endtask

  task automatic test_retire_kinds();
    logic [3:0] b;
    b = rob_tail;
    send_item(make_cmd(MODE_DISPATCH, KIND_REG, 4'd0, 32'd0, 32'd31, 32'h0000_0100));
    send_item(make_cmd(MODE_DISPATCH, KIND_STORE_B, 4'd0, 32'd0, 32'd0, 32'h0000_0104));
    send_item(make_cmd(MODE_DISPATCH, KIND_STORE_H, 4'd0, 32'd0, 32'd0, 32'h0000_0108));
    send_item(make_cmd(MODE_DISPATCH, KIND_STORE_W, 4'd0, 32'd0, 32'd0, 32'h0000_010C));
    send_item(make_cmd(MODE_DISPATCH, KIND_JALR, 4'd0, 32'd0, 32'd5, 32'hFFFF_FFFC));
    send_item(make_cmd(MODE_DISPATCH, KIND_BRANCH, 4'd0, 32'd1, 32'h0000_0300, 32'h0000_0200));
    send_item(make_cmd(MODE_DISPATCH, KIND_BRANCH, 4'd0, 32'd0, 32'h1234_5678, 32'h0000_0400));
    send_item(make_cmd(MODE_DISPATCH, KIND_BRANCH, 4'd0, 32'd7, 32'hABCD_0000, 32'hFFFF_FFFC));
    send_item(make_cmd(MODE_DISPATCH, KIND_EXIT, 4'd0, 32'h5A5A_5A5A, 32'd0, 32'h0000_0500));
    send_item(make_cmd(MODE_DISPATCH, KIND_SPARE, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'h0000_0504));
    send_item(make_cmd(MODE_WRITEBACK, KIND_BRANCH, b, 32'hFFFF_FFFF, 32'd0, 32'd0));
    send_item(make_cmd(MODE_STORE_WB, KIND_BRANCH, b + 4'd1, 32'h0000_00A5, 32'hFFFF_FFFF, 32'd0));
    send_item(make_cmd(MODE_STORE_WB, KIND_BRANCH, b + 4'd2, 32'hFFFF_FFFF, 32'd0, 32'd0));
    send_item(make_cmd(MODE_STORE_WB, KIND_BRANCH, b + 4'd3, 32'h1234_5678, 32'h0000_1000, 32'd0));
    send_item(make_cmd(MODE_WRITEBACK, KIND_BRANCH, b + 4'd4, 32'h8000_0000, 32'd0, 32'd0));
    send_item(make_cmd(MODE_WRITEBACK, KIND_BRANCH, b + 4'd5, 32'd1, 32'd0, 32'd0));
    send_item(make_cmd(MODE_MARK, KIND_BRANCH, b + 4'd6, 32'd0, 32'd0, 32'd0));
    send_item(make_cmd(MODE_WRITEBACK, KIND_BRANCH, b + 4'd7, 32'd0, 32'd0, 32'd0));
    send_item(make_cmd(MODE_MARK, KIND_BRANCH, b + 4'd8, 32'd0, 32'd0, 32'd0));
    send_item(make_cmd(MODE_MARK, KIND_BRANCH, b + 4'd9, 32'd0, 32'd0, 32'd0));
    repeat (7) send_item(make_cmd(MODE_COMMIT, KIND_BRANCH, 4'd0, 32'd0, 32'd0, 32'd0));
    send_item(make_cmd(MODE_WRITEBACK, KIND_BRANCH, b + 4'd6, 32'd5, 32'd0, 32'd0));
    repeat (4) send_item(make_cmd(MODE_COMMIT, KIND_BRANCH, 4'd0, 32'd0, 32'd0, 32'd0));
    send_item(make_cmd(MODE_MARK, KIND_BRANCH, b, 32'd0, 32'd0, 32'd0));
  endtask

  task automatic test_full_buffer();
    repeat (SLOTS) begin
      send_item(make_cmd(MODE_DISPATCH, KIND_REG, 4'd0, random_word(), random_word(),
                         random_word()));
    end
    send_item(make_cmd(MODE_DISPATCH, KIND_REG, 4'd0, 32'd1, 32'd1, 32'd1));
    send_item(make_cmd(MODE_COMMIT, KIND_BRANCH, 4'd0, 32'd0, 32'd0, 32'd0));
    repeat (SLOTS) begin
      send_item(make_cmd(MODE_WRITEBACK, KIND_BRANCH, rob_head, random_word(), 32'd0, 32'd0));
      send_item(make_cmd(MODE_COMMIT, KIND_BRANCH, 4'd0, 32'd0, 32'd0, 32'd0));
    end
  endtask

  task automatic test_random_traffic();
    int bias;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(2))
        0: bias = 15;
        1: bias = 30;
        default: bias = 50;
      endcase
      if (seg % 5 == 0) begin
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end else begin
        source_gaps = ($urandom_range(3) != 0);
        sink_stalls = ($urandom_range(3) != 0);
      end
      repeat (SEGMENT_ITEMS) send_item(random_cmd(bias));
      if (seg == SEGMENTS / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    for (int s = 0; s < SLOTS; s++) begin
      rob_kind[s] = '0;
      rob_value[s] = '0;
      rob_dest[s] = '0;
      rob_pc[s] = '0;
      rob_ready[s] = 1'b0;
      rob_busy[s] = 1'b0;
      rob_dispatched[s] = 1'b0;
    end
    rob_head = '0;
    rob_tail = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_idle_cases();
    drain_results();
    test_retire_kinds();
    drain_results();
    test_full_buffer();
    drain_results();
    test_random_traffic();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
